/* hw/rtl/bfha_pkg.sv */
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared constants and types for the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int POOL_BYTES = 65536;
  localparam int HDR_BYTES  = 3;
  localparam int AW         = $clog2(POOL_BYTES);
  // Walk pointer holds an address plus a block size plus a header.
  localparam int PW         = AW + 2;
  localparam int SW         = 16;
  localparam int WORD_W     = SW + 1;

  localparam int IN_W  = 40;
  localparam int OUT_W = 72;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DBL_FREE  = 2'd3
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

/* hw/rtl/bfha_ram.sv */
// ----------------------------------------------------------------------------
// bfha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/best_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit allocator with coalescing over a chain of block headers.
// ----------------------------------------------------------------------------
// Every transaction walks the header chain held in one header RAM, indexed by
// header address, with one read per block through the RAM's registered read
// port. An allocate runs a search walk, one or two header writes and a
// statistics walk; a free walks to the freed block, checks the neighbor after
// it, writes one merged header and runs the statistics walk. After reset the
// block writes the initial header before it takes input. One result follows
// each input transaction; a new input is taken as soon as the previous one has
// reached the output register.
module best_fit_heap_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // op[0], request_size[16:1], handle[32:17], zero fill above
  input  logic [bfha_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], data_offset[17:2], total_free[33:18],
  // largest_free[50:34], smallest_free[67:51], zero fill above
  output logic [bfha_pkg::OUT_W-1:0]  m_tdata
);

  localparam int PW = bfha_pkg::PW;
  localparam int AW = bfha_pkg::AW;
  localparam int SW = bfha_pkg::SW;
  localparam logic [PW-1:0] POOL   = PW'(bfha_pkg::POOL_BYTES);
  localparam logic [PW-1:0] HDR    = PW'(bfha_pkg::HDR_BYTES);
  localparam logic [PW-1:0] HDR_LIM = PW'(bfha_pkg::POOL_BYTES - 2);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SRCH_RD, S_SRCH_EV, S_ALLOC_WR1, S_ALLOC_WR2,
    S_NXT_RD, S_NXT_EV, S_FREE_WR, S_STAT_RD, S_STAT_EV, S_DONE
  } state_t;

  state_t            state;
  logic [PW-1:0]     ptr;
  logic              op;
  logic [SW-1:0]     req;
  logic [SW-1:0]     handle;
  logic              found;
  logic [PW-1:0]     best;
  logic [SW-1:0]     best_sz;
  logic [SW-1:0]     best_slack;
  bfha_pkg::status_t status;
  logic [PW-1:0]     idx;
  logic [PW-1:0]     tot;
  logic [PW-1:0]     prev;
  logic [SW-1:0]     prev_sz;
  logic              prev_free;
  logic              have_prev;
  logic [SW-1:0]     st_total;
  logic [SW-1:0]     st_large;
  logic [SW-1:0]     st_small;
  logic              st_any;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [bfha_pkg::WORD_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [bfha_pkg::WORD_W-1:0] ram_rdata;

  logic          rd_used;
  logic [SW-1:0] rd_sz;
  logic [PW-1:0] next_ptr;
  logic [PW-1:0] need;
  logic          fits;
  logic [SW-1:0] slack;
  logic [SW-1:0] left;
  logic          split;
  logic          hdr_ok;
  logic          hit;
  logic [PW-1:0] merged;

  bfha_ram #(
    .WIDTH(bfha_pkg::WORD_W),
    .DEPTH(bfha_pkg::POOL_BYTES)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_used  = ram_rdata[SW];
  assign rd_sz    = ram_rdata[SW-1:0];
  assign next_ptr = ptr + PW'(rd_sz) + HDR;
  assign need     = PW'(req) + HDR;
  assign fits     = !rd_used && (PW'(rd_sz) >= need);
  assign slack    = SW'(PW'(rd_sz) - need);
  assign left     = best_sz - req;
  assign split    = left > SW'(bfha_pkg::HDR_BYTES);
  assign hdr_ok   = ptr < HDR_LIM;
  assign hit      = (ptr + HDR) == PW'(handle);
  assign merged   = tot + PW'(prev_sz) + HDR;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = '0;
    ram_raddr = ptr[AW-1:0];
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b0, SW'(bfha_pkg::POOL_BYTES - bfha_pkg::HDR_BYTES)};
      end
      S_ALLOC_WR1: begin
        ram_we    = split;
        ram_waddr = AW'(best + HDR + PW'(req));
        ram_wdata = {1'b0, left - SW'(bfha_pkg::HDR_BYTES)};
      end
      S_ALLOC_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = best[AW-1:0];
        ram_wdata = {1'b1, split ? req : best_sz};
      end
      S_FREE_WR: begin
        ram_we = 1'b1;
        if (have_prev && prev_free) begin
          ram_waddr = prev[AW-1:0];
          ram_wdata = {1'b0, merged[SW-1:0]};
        end else begin
          ram_waddr = idx[AW-1:0];
          ram_wdata = {1'b0, tot[SW-1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (s_tvalid) begin
            op        <= s_tdata[0];
            req       <= s_tdata[16:1];
            handle    <= s_tdata[32:17];
            ptr       <= '0;
            found     <= 1'b0;
            have_prev <= 1'b0;
            state     <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          if (ptr < POOL && hdr_ok) begin
            state <= S_SRCH_EV;
          end else begin
            if (op == bfha_pkg::OP_ALLOC) begin
              status <= found ? bfha_pkg::ST_OK : bfha_pkg::ST_NO_MEM;
              state  <= found ? S_ALLOC_WR1 : S_STAT_RD;
            end else begin
              status <= bfha_pkg::ST_NOT_FOUND;
              state  <= S_STAT_RD;
            end
            if (!(found && op == bfha_pkg::OP_ALLOC)) begin
              ptr <= '0;
            end
          end
        end
        S_SRCH_EV: begin
          if (op == bfha_pkg::OP_ALLOC) begin
            if (fits && (!found || slack < best_slack)) begin
              found      <= 1'b1;
              best       <= ptr;
              best_sz    <= rd_sz;
              best_slack <= slack;
            end
            ptr   <= next_ptr;
            state <= S_SRCH_RD;
          end else if (hit) begin
            if (!rd_used) begin
              status <= bfha_pkg::ST_DBL_FREE;
              ptr    <= '0;
              state  <= S_STAT_RD;
            end else begin
              status <= bfha_pkg::ST_OK;
              idx    <= ptr;
              tot    <= PW'(rd_sz);
              ptr    <= next_ptr;
              state  <= S_NXT_RD;
            end
          end else begin
            prev      <= ptr;
            prev_sz   <= rd_sz;
            prev_free <= !rd_used;
            have_prev <= 1'b1;
            ptr       <= next_ptr;
            state     <= S_SRCH_RD;
          end
        end
        S_ALLOC_WR1: state <= S_ALLOC_WR2;
        S_ALLOC_WR2: begin
          ptr   <= '0;
          state <= S_STAT_RD;
        end
        S_NXT_RD: begin
          // The neighbor after the freed block exists only if its header fits.
          state <= hdr_ok ? S_NXT_EV : S_FREE_WR;
        end
        S_NXT_EV: begin
          if (!rd_used) begin
            tot <= tot + PW'(rd_sz) + HDR;
          end
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          ptr   <= '0;
          state <= S_STAT_RD;
        end
        S_STAT_RD: begin
          if (ptr == '0) begin
            st_total <= '0;
            st_any   <= 1'b0;
          end
          state <= hdr_ok ? S_STAT_EV : S_DONE;
        end
        S_STAT_EV: begin
          if (!rd_used) begin
            st_total <= st_total + rd_sz;
            if (!st_any || rd_sz > st_large) begin
              st_large <= rd_sz;
            end
            if (!st_any || rd_sz < st_small) begin
              st_small <= rd_sz;
            end
            st_any <= 1'b1;
          end
          ptr   <= next_ptr;
          state <= S_STAT_RD;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0,
                         st_any ? {1'b0, st_small} : {(SW+1){1'b1}},
                         st_any ? {1'b0, st_large} : {(SW+1){1'b1}},
                         st_total,
                         (op == bfha_pkg::OP_ALLOC && status == bfha_pkg::ST_OK)
                           ? SW'(best + HDR) : SW'(0),
                         status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/bfha_checker.sv */
// ----------------------------------------------------------------------------
// bfha_checker
// Port-level checks for the best-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfha_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bfha_pkg::OUT_W-1:0] m_tdata
);

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input closes once a transaction is accepted, while the walk runs.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // A failed request never returns an offset.
  a_fail_no_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != bfha_pkg::ST_OK |-> m_tdata[17:2] == 16'd0)
    else $error("offset on failure");

  // Largest and smallest are both "none" together, and then nothing is free.
  a_stats_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[50:34] == 17'h1ffff
      |-> m_tdata[67:51] == 17'h1ffff && m_tdata[33:18] == 16'd0)
    else $error("inconsistent free statistics");

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
